>>> rtl/core/v3alu_pkg.sv
// Shared types, opcodes, pipeline depths and saturation helper for the vector ALU.
package v3alu_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Stage counts of the pipeline sections
  localparam int LANE_LAT = 3;
  localparam int SQ_LAT   = 32;
  localparam int DIV_QB   = 33;
  localparam int DIV_LAT  = DIV_QB + 2;
  localparam int PIPE_LAT = 1 + LANE_LAT + 1 + SQ_LAT + DIV_LAT + 1;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_DOT    = 4'd4,
    OP_CROSS  = 4'd5,
    OP_DISTSQ = 4'd6,
    OP_DIST   = 4'd7,
    OP_LENGTH = 4'd8,
    OP_NORM   = 4'd9,
    OP_NEG    = 4'd10,
    OP_EQUAL  = 4'd11
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
  } ctx_t;

  typedef struct packed {
    ctx_t             ctx;
    logic [2:0][31:0] res;
    logic [31:0]      scalar;
    logic             eq;
    logic             ov;
  } early_t;

  typedef struct packed {
    op_t              op;
    logic [2:0]       a_neg;
    logic [2:0]       a_zero;
    logic [2:0]       b_zero;
    logic             len_zero;
    logic [2:0][31:0] res;
    logic [31:0]      scalar;
    logic             eq;
    logic             ov;
  } post_t;

  // Saturate a wide signed value to 32 bits; returns {overflow, value}
  function automatic logic [32:0] sat_q32(input logic signed [67:0] v);
    logic [32:0] r;
    if (v > 68'sd2147483647) begin
      r = {1'b1, Q_MAX};
    end else if (v < -68'sd2147483648) begin
      r = {1'b1, Q_MIN};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/v3alu_lane.sv
// One component lane: operand select, two multipliers and the lane sum.
module v3alu_lane import v3alu_pkg::*; #(
  parameter int LANE = 0
) (
  input  logic               clk,
  input  logic               en,
  input  op_t                op,
  input  logic [2:0][31:0]   a,
  input  logic [2:0][31:0]   b,
  output logic signed [66:0] sum,
  output logic [31:0]        simple,
  output logic               simple_ov
);

  localparam int J = (LANE + 1) % 3;
  localparam int K = (LANE + 2) % 3;

  logic signed [32:0] ai, bi, aj, bj, ak, bk;
  logic signed [32:0] diff, dmag, amag, clamp;
  logic signed [32:0] x1_nxt, y1_nxt, x2_nxt, y2_nxt;
  logic [32:0]        sim_nxt;

  logic signed [32:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [65:0] p1_r, p2_r;
  logic signed [66:0] sum_r;
  logic [31:0]        sim1_r, sim2_r, sim3_r;
  logic               sov1_r, sov2_r, sov3_r;

  always_comb begin
    ai = 33'($signed(a[LANE]));
    bi = 33'($signed(b[LANE]));
    aj = 33'($signed(a[J]));
    bj = 33'($signed(b[J]));
    ak = 33'($signed(a[K]));
    bk = 33'($signed(b[K]));
    diff = ai - bi;
    dmag = diff[32] ? -diff : diff;
    // Clamp the difference magnitude to 2^31 before squaring
    clamp = (dmag > 33'sh0_8000_0000) ? 33'sh0_8000_0000 : dmag;
    amag = ai[32] ? -ai : ai;
    x1_nxt = '0;
    y1_nxt = '0;
    x2_nxt = '0;
    y2_nxt = '0;
    case (op)
      OP_MUL, OP_DOT: begin
        x1_nxt = ai;
        y1_nxt = bi;
      end
      OP_CROSS: begin
        x1_nxt = aj;
        y1_nxt = bk;
        x2_nxt = -ak;
        y2_nxt = bj;
      end
      OP_DISTSQ, OP_DIST: begin
        x1_nxt = clamp;
        y1_nxt = clamp;
      end
      OP_LENGTH, OP_NORM: begin
        x1_nxt = amag;
        y1_nxt = amag;
      end
      default: begin
        x1_nxt = '0;
      end
    endcase
    case (op)
      OP_ADD:  sim_nxt = sat_q32(68'(ai + bi));
      OP_SUB:  sim_nxt = sat_q32(68'(ai - bi));
      OP_NEG:  sim_nxt = sat_q32(68'(-ai));
      default: sim_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= x1_nxt;
      y1_r   <= y1_nxt;
      x2_r   <= x2_nxt;
      y2_r   <= y2_nxt;
      sim1_r <= sim_nxt[31:0];
      sov1_r <= sim_nxt[32];
      p1_r   <= x1_r * y1_r;
      p2_r   <= x2_r * y2_r;
      sim2_r <= sim1_r;
      sov2_r <= sov1_r;
      sum_r  <= 67'(p1_r) + 67'(p2_r);
      sim3_r <= sim2_r;
      sov3_r <= sov2_r;
    end
  end

  assign sum       = sum_r;
  assign simple    = sim3_r;
  assign simple_ov = sov3_r;

endmodule

>>> rtl/core/v3alu_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module v3alu_sqrt import v3alu_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  logic [33:0] rem_r  [SQ_LAT];
  logic [31:0] root_r [SQ_LAT];
  logic [63:0] rad_r  [SQ_LAT];

  for (genvar k = 0; k < SQ_LAT; k++) begin : g_step
    logic [33:0] rem_i;
    logic [31:0] root_i;
    logic [63:0] rad_i;
    logic [35:0] cur, trial;
    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign rad_i  = rad_r[k-1];
    end
    assign cur   = {rem_i, rad_i[63:62]};
    assign trial = {2'b00, root_i, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem_r[k]  <= 34'(cur - trial);
          root_r[k] <= {root_i[30:0], 1'b1};
        end else begin
          rem_r[k]  <= cur[33:0];
          root_r[k] <= {root_i[30:0], 1'b0};
        end
        rad_r[k] <= {rad_i[61:0], 2'b00};
      end
    end
  end

  assign root = root_r[SQ_LAT-1];

endmodule

>>> rtl/core/v3alu_div.sv
// Pipelined restoring divider with signed saturation of the quotient.
module v3alu_div import v3alu_pkg::*; #(
  parameter int NUM_W = 32 + FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [31:0]      den,
  input  logic             neg,
  output logic [31:0]      q,
  output logic             ov
);

  logic [31:0]       prem_r;
  logic [DIV_QB-1:0] plow_r;
  logic [31:0]       pden_r;
  logic              pneg_r, pbig_r;

  logic [31:0]       rem_r  [DIV_QB];
  logic [DIV_QB-1:0] low_r  [DIV_QB];
  logic [31:0]       den_r  [DIV_QB];
  logic              neg_r  [DIV_QB];
  logic              big_r  [DIV_QB];

  logic [31:0]       q_r;
  logic              ov_r;
  logic [DIV_QB-1:0] qm;
  logic [32:0]       fin_nxt;

  // Prep: a quotient that needs more than DIV_QB bits always saturates
  always_ff @(posedge clk) begin
    if (en) begin
      prem_r <= 32'(num[NUM_W-1:DIV_QB]);
      plow_r <= num[DIV_QB-1:0];
      pden_r <= den;
      pneg_r <= neg;
      pbig_r <= (32'(num[NUM_W-1:DIV_QB]) >= den);
    end
  end

  for (genvar k = 0; k < DIV_QB; k++) begin : g_step
    logic [31:0]       rem_i, den_i;
    logic [DIV_QB-1:0] low_i;
    logic              neg_i, big_i, ge;
    logic [32:0]       sh;
    if (k == 0) begin : g_first
      assign rem_i = prem_r;
      assign low_i = plow_r;
      assign den_i = pden_r;
      assign neg_i = pneg_r;
      assign big_i = pbig_r;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign low_i = low_r[k-1];
      assign den_i = den_r[k-1];
      assign neg_i = neg_r[k-1];
      assign big_i = big_r[k-1];
    end
    assign sh = {rem_i, low_i[DIV_QB-1]};
    assign ge = (sh >= {1'b0, den_i});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? 32'(sh - {1'b0, den_i}) : sh[31:0];
        low_r[k] <= {low_i[DIV_QB-2:0], ge};
        den_r[k] <= den_i;
        neg_r[k] <= neg_i;
        big_r[k] <= big_i;
      end
    end
  end

  assign qm = low_r[DIV_QB-1];

  always_comb begin
    if (big_r[DIV_QB-1]) begin
      fin_nxt = {1'b1, neg_r[DIV_QB-1] ? Q_MIN : Q_MAX};
    end else if (!neg_r[DIV_QB-1]) begin
      fin_nxt = (qm > 33'h0_7fff_ffff) ? {1'b1, Q_MAX} : {1'b0, qm[31:0]};
    end else begin
      fin_nxt = (qm > 33'h0_8000_0000) ? {1'b1, Q_MIN} : {1'b0, 32'(-qm[31:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r  <= fin_nxt[31:0];
      ov_r <= fin_nxt[32];
    end
  end

  assign q  = q_r;
  assign ov = ov_r;

endmodule

>>> rtl/core/vector3_fixed_point_alu_core.sv
// Top level of the three-component fixed-point vector ALU.
// Pipeline: 73 register stages (1 input, 3 lane, 1 merge, 32 square-root, 35 divider,
//   1 output).
// Throughput: one transaction per cycle while results are taken;
//   every operation walks the full pipeline.
// The whole pipeline advances together and holds while a result waits unaccepted.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers keep data.
module vector3_fixed_point_alu_core import v3alu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_opcode,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_x,
  output logic signed [31:0] out_res_y,
  output logic signed [31:0] out_res_z,
  output logic signed [31:0] out_scalar_out,
  output logic               out_is_equal,
  output logic               out_div_zero,
  output logic               out_overflow
);

  localparam int NUM_W = 32 + FRAC_BITS;

  logic                en;
  logic [PIPE_LAT-1:0] vld_r;

  // Input stage and the context that rides alongside the lanes
  ctx_t ctx0_r;
  ctx_t ctx_d_r [LANE_LAT];

  // Lane outputs
  logic signed [66:0] lane_sum [3];
  logic [31:0]        lane_sim [3];
  logic [2:0]         lane_sov;

  // Merge stage
  ctx_t               ctx4_r;
  logic [2:0][31:0]   vec4_r, vec4_nxt;
  logic [2:0]         vov4_r, vov4_nxt;
  logic signed [67:0] tot4_r, tot4_nxt;

  // Delay lines that line up with the square root and the dividers
  early_t      early_nxt;
  early_t      early_d_r [SQ_LAT];
  logic [31:0] root;
  post_t       post_nxt;
  post_t       post_d_r [DIV_LAT];

  logic [NUM_W-1:0] div_num [3];
  logic [31:0]      div_den [3];
  logic [2:0]       div_neg;
  logic [31:0]      div_q [3];
  logic [2:0]       div_ov;

  // Output stage
  logic [2:0][31:0] res_r, res_nxt;
  logic [31:0]      scalar_r, scalar_nxt;
  logic             eq_r, eq_nxt, dz_r, dz_nxt, ov_r, ov_nxt;

  // Advance everything unless the output holds a result that is not taken
  assign en       = !vld_r[PIPE_LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx0_r.op <= op_t'(in_opcode);
      ctx0_r.a  <= {in_a_z, in_a_y, in_a_x};
      ctx0_r.b  <= {in_b_z, in_b_y, in_b_x};
      ctx_d_r[0] <= ctx0_r;
      for (int i = 1; i < LANE_LAT; i++) begin
        ctx_d_r[i] <= ctx_d_r[i-1];
      end
    end
  end

  // Three lanes, one per component
  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3alu_lane #(.LANE(i)) u_lane (
      .clk       (clk),
      .en        (en),
      .op        (ctx0_r.op),
      .a         (ctx0_r.a),
      .b         (ctx0_r.b),
      .sum       (lane_sum[i]),
      .simple    (lane_sim[i]),
      .simple_ov (lane_sov[i])
    );
  end

  // Merge: per-lane scaling for MUL and CROSS, lane pass-through for ADD, SUB and NEG, and the three-lane total
  always_comb begin
    logic signed [66:0] sh;
    logic [32:0]        s;
    for (int i = 0; i < 3; i++) begin
      sh = lane_sum[i] >>> FRAC_BITS;
      s  = sat_q32(68'(sh));
      case (ctx_d_r[LANE_LAT-1].op)
        OP_MUL, OP_CROSS: begin
          vec4_nxt[i] = s[31:0];
          vov4_nxt[i] = s[32];
        end
        OP_ADD, OP_SUB, OP_NEG: begin
          vec4_nxt[i] = lane_sim[i];
          vov4_nxt[i] = lane_sov[i];
        end
        default: begin
          vec4_nxt[i] = '0;
          vov4_nxt[i] = 1'b0;
        end
      endcase
    end
    tot4_nxt = 68'(lane_sum[0]) + 68'(lane_sum[1]) + 68'(lane_sum[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx4_r <= ctx_d_r[LANE_LAT-1];
      vec4_r <= vec4_nxt;
      vov4_r <= vov4_nxt;
      tot4_r <= tot4_nxt;
    end
  end

  // Scalar results that need no root or quotient
  always_comb begin
    logic [32:0] s;
    s = sat_q32(tot4_r >>> FRAC_BITS);
    early_nxt.ctx    = ctx4_r;
    early_nxt.res    = vec4_r;
    early_nxt.scalar = '0;
    early_nxt.eq     = 1'b0;
    early_nxt.ov     = |vov4_r;
    case (ctx4_r.op)
      OP_DOT, OP_DISTSQ: begin
        early_nxt.scalar = s[31:0];
        early_nxt.ov     = s[32];
      end
      OP_EQUAL: begin
        early_nxt.eq = (ctx4_r.a == ctx4_r.b);
      end
      default: begin
        early_nxt.scalar = '0;
      end
    endcase
  end

  // Sum of squares feeds the root; it stays below 2^64
  v3alu_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (tot4_r[63:0]),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      early_d_r[0] <= early_nxt;
      for (int i = 1; i < SQ_LAT; i++) begin
        early_d_r[i] <= early_d_r[i-1];
      end
    end
  end

  // Root is ready: finish dist and length, set up the dividers
  always_comb begin
    early_t      e;
    logic [31:0] av, bv, amag, bmag;
    e = early_d_r[SQ_LAT-1];
    post_nxt.op       = e.ctx.op;
    post_nxt.len_zero = (root == '0);
    post_nxt.res      = e.res;
    post_nxt.scalar   = e.scalar;
    post_nxt.eq       = e.eq;
    post_nxt.ov       = e.ov;
    for (int i = 0; i < 3; i++) begin
      av   = e.ctx.a[i];
      bv   = e.ctx.b[i];
      amag = av[31] ? 32'(-av) : av;
      bmag = bv[31] ? 32'(-bv) : bv;
      post_nxt.a_neg[i]  = av[31];
      post_nxt.a_zero[i] = (av == '0);
      post_nxt.b_zero[i] = (bv == '0);
      div_num[i] = {amag, {FRAC_BITS{1'b0}}};
      div_den[i] = (e.ctx.op == OP_DIV) ? bmag : root;
      div_neg[i] = (e.ctx.op == OP_DIV) ? (av[31] ^ bv[31]) : av[31];
    end
    if (e.ctx.op == OP_DIST || e.ctx.op == OP_LENGTH) begin
      post_nxt.scalar = root[31] ? Q_MAX : root;
      post_nxt.ov     = root[31];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3alu_div #(.NUM_W(NUM_W)) u_div (
      .clk (clk),
      .en  (en),
      .num (div_num[i]),
      .den (div_den[i]),
      .neg (div_neg[i]),
      .q   (div_q[i]),
      .ov  (div_ov[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      post_d_r[0] <= post_nxt;
      for (int i = 1; i < DIV_LAT; i++) begin
        post_d_r[i] <= post_d_r[i-1];
      end
    end
  end

  // Final merge: quotients, division-by-zero cases, zero-length normalize
  always_comb begin
    post_t p;
    p          = post_d_r[DIV_LAT-1];
    res_nxt    = p.res;
    scalar_nxt = p.scalar;
    eq_nxt     = p.eq;
    dz_nxt     = 1'b0;
    ov_nxt     = p.ov;
    case (p.op)
      OP_DIV: begin
        dz_nxt = |p.b_zero;
        for (int i = 0; i < 3; i++) begin
          if (!p.b_zero[i]) begin
            res_nxt[i] = div_q[i];
            ov_nxt     = ov_nxt | div_ov[i];
          end else if (p.a_zero[i]) begin
            res_nxt[i] = '0;
          end else begin
            res_nxt[i] = p.a_neg[i] ? Q_MIN : Q_MAX;
            ov_nxt     = 1'b1;
          end
        end
      end
      OP_NORM: begin
        // A zero vector normalizes to zero with no flag
        if (!p.len_zero) begin
          for (int i = 0; i < 3; i++) begin
            res_nxt[i] = div_q[i];
            ov_nxt     = ov_nxt | div_ov[i];
          end
        end
      end
      default: begin
        dz_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r    <= res_nxt;
      scalar_r <= scalar_nxt;
      eq_r     <= eq_nxt;
      dz_r     <= dz_nxt;
      ov_r     <= ov_nxt;
    end
  end

  assign out_valid      = vld_r[PIPE_LAT-1];
  assign out_res_x      = res_r[0];
  assign out_res_y      = res_r[1];
  assign out_res_z      = res_r[2];
  assign out_scalar_out = scalar_r;
  assign out_is_equal   = eq_r;
  assign out_div_zero   = dz_r;
  assign out_overflow   = ov_r;

endmodule

>>> rtl/core/v3alu_checker.sv
// Port-level checker for the vector ALU, bound to the top level.
module v3alu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [3:0]         in_opcode,
  input logic signed [31:0] in_a_x,
  input logic signed [31:0] in_a_y,
  input logic signed [31:0] in_a_z,
  input logic signed [31:0] in_b_x,
  input logic signed [31:0] in_b_y,
  input logic signed [31:0] in_b_z,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_res_x,
  input logic signed [31:0] out_res_y,
  input logic signed [31:0] out_res_z,
  input logic signed [31:0] out_scalar_out,
  input logic               out_is_equal,
  input logic               out_div_zero,
  input logic               out_overflow
);

  // Hold a waiting input transaction
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_opcode)
      && $stable(in_a_x) && $stable(in_a_y) && $stable(in_a_z)
      && $stable(in_b_x) && $stable(in_b_y) && $stable(in_b_z))
    else $error("waiting input transaction changed");

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_x) && $stable(out_scalar_out))
    else $error("stalled result changed");

  a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_equal |-> out_res_x == 0 && out_res_y == 0 && out_res_z == 0
      && out_scalar_out == 0 && !out_overflow && !out_div_zero)
    else $error("equal result carries other outputs");

  a_dz_vector: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |-> out_scalar_out == 0 && !out_is_equal)
    else $error("division flag on a scalar result");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind vector3_fixed_point_alu_core v3alu_checker u_v3alu_checker (.*);
